// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the ServerHello parser checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond_a implies cond_b in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, cond_a, cond_b) \
   label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
      else $error("assertion failed: same-cycle implication");

// Check that cond_a implies cond_b in the following cycle.
`define ASSERT_NEXT(label, clk, rst, cond_a, cond_b) \
   label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== src/tshp_pkg.sv =====
// ----------------------------------------------------------------------------
// tshp_pkg
// Types, constants and codes shared by the ServerHello parser modules.
// ----------------------------------------------------------------------------
package tshp_pkg;

   localparam logic [15:0] MIN_HELLO_LEN   = 16'd44;
   localparam logic [15:0] SUITE_AES128    = 16'h1301;
   localparam logic [15:0] SUITE_CHACHA    = 16'h1303;
   localparam logic [15:0] EXT_KEY_SHARE   = 16'd51;
   localparam logic [15:0] KEY_SHARE_MIN   = 16'd36;
   localparam logic [15:0] EXT_VERSIONS    = 16'd43;
   localparam logic [15:0] GROUP_X25519    = 16'h001d;
   localparam logic [15:0] VERSION_TLS13   = 16'h0304;
   localparam logic [15:0] X25519_KEY_LEN  = 16'd32;
   localparam logic [15:0] SESSION_LEN_POS = 16'd38;
   localparam logic [31:0] SHARE_WANT      = {GROUP_X25519, X25519_KEY_LEN};
   localparam logic [15:0] POSITION_MAX    = 16'hffff;

   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_SHORT      = 3'd1;
   localparam logic [2:0] STATUS_INCOMPLETE = 3'd2;
   localparam logic [2:0] STATUS_BAD_SUITE  = 3'd3;
   localparam logic [2:0] STATUS_TRUNCATED  = 3'd4;
   localparam logic [2:0] STATUS_NO_TLS13   = 3'd5;
   localparam logic [2:0] STATUS_NO_SHARE   = 3'd6;

   localparam logic [1:0] CIPHER_UNSET   = 2'd0;
   localparam logic [1:0] CIPHER_AES     = 2'd1;
   localparam logic [1:0] CIPHER_CHAPOLY = 2'd2;

   localparam logic [5:0] KEY_LEN_NONE   = 6'd0;
   localparam logic [5:0] KEY_LEN_AES    = 6'd16;
   localparam logic [5:0] KEY_LEN_CHACHA = 6'd32;

   typedef enum logic [4:0] {
      PH_HEADER   = 5'b00001,
      PH_FIXED    = 5'b00010,
      PH_EXT_HDR  = 5'b00100,
      PH_EXT_BODY = 5'b01000,
      PH_DONE     = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [15:0] byte_position;
      logic [8:0]  session_end;
      logic [7:0]  suite_high;
      logic [16:0] extensions_end;
      logic [31:0] ext_header;
      logic [15:0] ext_body_start;
      logic [31:0] group_check;
      phase_type   parse_phase;
      logic [2:0]  error_code;
      logic        share_found;
      logic        tls13_seen;
      logic [1:0]  chosen_cipher;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      byte_position:  16'd0,
      session_end:    9'd0,
      suite_high:     8'd0,
      extensions_end: 17'd0,
      ext_header:     32'd0,
      ext_body_start: 16'd0,
      group_check:    32'd0,
      parse_phase:    PH_HEADER,
      error_code:     STATUS_OK,
      share_found:    1'b0,
      tls13_seen:     1'b0,
      chosen_cipher:  CIPHER_UNSET
   };

   typedef struct packed {
      logic       has_key_byte;
      logic [7:0] key_value;
      logic [4:0] key_position;
      logic       is_verdict;
      logic [2:0] status;
      logic       cipher_choice;
      logic [5:0] key_bytes;
   } result_type;

endpackage

// ===== src/tls13_server_hello_parser_core.sv =====
// ----------------------------------------------------------------------------
// tls13_server_hello_parser_core
// Parses a TLS 1.3 ServerHello one byte per transaction, with the message
// length riding along on every byte and final_byte marking the last one. It
// skips the header, random and session id, picks AES-128-GCM (key length 16)
// or ChaCha20-Poly1305 (key length 32) from the cipher suite, walks the
// extensions, streams the 32 X25519 peer key bytes of each valid key share
// extension as result transactions, and gives a verdict on the final byte.
// Bytes that are neither key bytes nor final produce no result. The block
// takes one byte per cycle while the result register is not stalled; each
// byte is held in the input register and its result, if any, is loaded into
// the result register. The rate is set by the per-byte parse state update.
// Reset and every final byte return the parser to the message start.
// ----------------------------------------------------------------------------
module tls13_server_hello_parser_core
   import tshp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_message_length,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_has_key_byte,
   output logic [7:0]  rsp_key_value,
   output logic [4:0]  rsp_key_position,
   output logic        rsp_is_verdict,
   output logic [2:0]  rsp_status,
   output logic        rsp_cipher_choice,
   output logic [5:0]  rsp_key_bytes
);

   // Input register
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [7:0]  data_byte_ff;
   logic [15:0] message_length_ff;
   logic        final_byte_ff;

   // Parse state
   parse_state_type state_ff;
   parse_state_type state_in;

   result_type step_result;
   result_type out_result;
   logic       step_result_valid;
   logic       req_accept;
   logic       advance;

   // Advance the held byte whenever the result register is free or emptying.
   assign advance     = in_valid_ff & (~rsp_valid | ~rsp_stall);
   assign req_stall   = in_valid_ff & ~advance;
   assign req_accept  = req_valid & ~req_stall;
   assign in_valid_in = req_accept | (in_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture the byte; a stalled byte holds in place.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         data_byte_ff      <= req_data_byte;
         message_length_ff <= req_message_length;
         final_byte_ff     <= req_final_byte;
      end
   end

   tshp_step u_step (
      .state          (state_ff),
      .data_byte      (data_byte_ff),
      .message_length (message_length_ff),
      .final_byte     (final_byte_ff),
      .state_next     (state_in),
      .result         (step_result),
      .result_valid   (step_result_valid)
   );

   // Commit the parse state only when the byte moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   tshp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance & step_result_valid),
      .result_in  (step_result),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .result_out (out_result)
   );

   assign rsp_has_key_byte  = out_result.has_key_byte;
   assign rsp_key_value     = out_result.key_value;
   assign rsp_key_position  = out_result.key_position;
   assign rsp_is_verdict    = out_result.is_verdict;
   assign rsp_status        = out_result.status;
   assign rsp_cipher_choice = out_result.cipher_choice;
   assign rsp_key_bytes     = out_result.key_bytes;

endmodule

// ===== src/tshp_step.sv =====
// ----------------------------------------------------------------------------
// tshp_step
// Per-byte parse logic: next parse state and the result for one byte.
// ----------------------------------------------------------------------------
module tshp_step
   import tshp_pkg::*;
(
   input  parse_state_type state,
   input  logic [7:0]      data_byte,
   input  logic [15:0]     message_length,
   input  logic            final_byte,
   output parse_state_type state_next,
   output result_type      result,
   output logic            result_valid
);

   logic [16:0] pos_ext;
   logic [16:0] len_ext;
   logic [16:0] se_ext;
   logic [8:0]  se_new;
   logic [31:0] hdr_new;
   logic [31:0] grp_new;
   logic [15:0] ext_size;
   logic [15:0] ext_type;
   logic [15:0] body_off;
   logic [16:0] body_end;
   logic        start_hdr;
   logic [16:0] start_at;
   logic [16:0] start_hdr_end;
   logic        key_hit;
   logic [4:0]  key_pos;
   logic [2:0]  verdict;
   parse_state_type upd;

   assign pos_ext  = {1'b0, state.byte_position};
   assign len_ext  = {1'b0, message_length};
   assign se_ext   = {8'd0, state.session_end};
   assign se_new   = 9'd39 + {1'b0, data_byte};
   assign hdr_new  = {state.ext_header[23:0], data_byte};
   assign grp_new  = {state.group_check[23:0], data_byte};
   assign ext_size = state.ext_header[15:0];
   assign ext_type = state.ext_header[31:16];
   assign body_off = state.byte_position - state.ext_body_start;
   assign body_end = {1'b0, state.ext_body_start} + {1'b0, ext_size};

   always_comb begin
      upd       = state;
      start_hdr = 1'b0;
      start_at  = '0;
      key_hit   = 1'b0;
      key_pos   = '0;
      if ((state.byte_position < message_length) && (state.parse_phase != PH_DONE)) begin
         case (state.parse_phase)
            PH_HEADER: begin
               if (state.byte_position == SESSION_LEN_POS) begin
                  upd.session_end = se_new;
                  if (({8'd0, se_new} + 17'd3) > len_ext) begin
                     upd.error_code  = STATUS_INCOMPLETE;
                     upd.parse_phase = PH_DONE;
                  end else begin
                     upd.parse_phase = PH_FIXED;
                  end
               end
            end
            PH_FIXED: begin
               if (pos_ext == se_ext) begin
                  upd.suite_high = data_byte;
               end else if (pos_ext == se_ext + 17'd1) begin
                  if ({state.suite_high, data_byte} == SUITE_AES128) begin
                     upd.chosen_cipher = CIPHER_AES;
                  end else if ({state.suite_high, data_byte} == SUITE_CHACHA) begin
                     upd.chosen_cipher = CIPHER_CHAPOLY;
                  end else begin
                     upd.error_code  = STATUS_BAD_SUITE;
                     upd.parse_phase = PH_DONE;
                  end
               end else if (pos_ext == se_ext + 17'd2) begin
                  if (se_ext + 17'd5 > len_ext) begin
                     upd.error_code  = STATUS_TRUNCATED;
                     upd.parse_phase = PH_DONE;
                  end
               end else if (pos_ext == se_ext + 17'd3) begin
                  upd.extensions_end = {1'b0, data_byte, 8'd0};
               end else if (pos_ext == se_ext + 17'd4) begin
                  upd.extensions_end = se_ext + 17'd5
                                     + (state.extensions_end | {9'd0, data_byte});
                  start_hdr = 1'b1;
                  start_at  = se_ext + 17'd5;
               end
            end
            PH_EXT_HDR: begin
               upd.ext_header = hdr_new;
               if (pos_ext + 17'd1 == {1'b0, state.ext_body_start}) begin
                  if ({1'b0, state.ext_body_start} + {1'b0, hdr_new[15:0]} > len_ext) begin
                     upd.parse_phase = PH_DONE;
                  end else if (hdr_new[15:0] == 16'd0) begin
                     start_hdr = 1'b1;
                     start_at  = {1'b0, state.ext_body_start};
                  end else begin
                     upd.parse_phase = PH_EXT_BODY;
                     upd.group_check = '0;
                  end
               end
            end
            PH_EXT_BODY: begin
               if ((ext_type == EXT_KEY_SHARE) && (ext_size >= KEY_SHARE_MIN)) begin
                  if (body_off < 16'd4) begin
                     upd.group_check = grp_new;
                     if ((body_off == 16'd3) && (grp_new == SHARE_WANT)) begin
                        upd.share_found = 1'b1;
                     end
                  end else if ((body_off < 16'd4 + X25519_KEY_LEN)
                               && (state.group_check == SHARE_WANT)) begin
                     key_hit = 1'b1;
                     key_pos = 5'(body_off - 16'd4);
                  end
               end else if ((ext_type == EXT_VERSIONS) && (ext_size == 16'd2)) begin
                  if (body_off == 16'd0) begin
                     upd.group_check = {24'd0, data_byte};
                  end else begin
                     upd.tls13_seen = (grp_new == {16'd0, VERSION_TLS13});
                  end
               end
               if (body_off + 16'd1 == ext_size) begin
                  start_hdr = 1'b1;
                  start_at  = body_end;
               end
            end
            default: begin
            end
         endcase
      end

      // Open the next extension header, or stop the walk at the area or message end.
      start_hdr_end = start_at + 17'd4;
      if (start_hdr) begin
         if ((start_hdr_end > upd.extensions_end) || (start_hdr_end > len_ext)) begin
            upd.parse_phase = PH_DONE;
         end else begin
            upd.parse_phase    = PH_EXT_HDR;
            upd.ext_body_start = start_hdr_end[15:0];
            upd.ext_header     = '0;
         end
      end
   end

   always_comb begin
      if (message_length < MIN_HELLO_LEN) begin
         verdict = STATUS_SHORT;
      end else if (upd.error_code != STATUS_OK) begin
         verdict = upd.error_code;
      end else if (pos_ext + 17'd1 < len_ext) begin
         verdict = STATUS_TRUNCATED;
      end else if (!upd.tls13_seen) begin
         verdict = STATUS_NO_TLS13;
      end else if (!upd.share_found) begin
         verdict = STATUS_NO_SHARE;
      end else begin
         verdict = STATUS_OK;
      end
   end

   always_comb begin
      result.has_key_byte  = key_hit;
      result.key_value     = key_hit ? data_byte : 8'd0;
      result.key_position  = key_hit ? key_pos : 5'd0;
      result.is_verdict    = final_byte;
      result.status        = final_byte ? verdict : STATUS_OK;
      result.cipher_choice = (upd.chosen_cipher == CIPHER_CHAPOLY);
      case (upd.chosen_cipher)
         CIPHER_AES:     result.key_bytes = KEY_LEN_AES;
         CIPHER_CHAPOLY: result.key_bytes = KEY_LEN_CHACHA;
         default:        result.key_bytes = KEY_LEN_NONE;
      endcase
   end

   assign result_valid = key_hit | final_byte;

   always_comb begin
      if (final_byte) begin
         state_next = STATE_RESET;
      end else begin
         state_next = upd;
         if (state.byte_position != POSITION_MAX) begin
            state_next.byte_position = state.byte_position + 16'd1;
         end
      end
   end

endmodule

// ===== src/tshp_out_reg.sv =====
// ----------------------------------------------------------------------------
// tshp_out_reg
// Result register: holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module tshp_out_reg
   import tshp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result_in,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output result_type result_out
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // Keep the result while the receiver stalls; load replaces it otherwise.
   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign result_out = result_ff;

endmodule

// ===== src/tshp_checker.sv =====
// ----------------------------------------------------------------------------
// tshp_checker
// Port-level checks on the result transactions of the ServerHello parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tshp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_has_key_byte,
   input logic [7:0] rsp_key_value,
   input logic [4:0] rsp_key_position,
   input logic       rsp_is_verdict,
   input logic [2:0] rsp_status,
   input logic       rsp_cipher_choice,
   input logic [5:0] rsp_key_bytes
);

   // A stalled result holds its key byte.
   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_key_value) && $stable(rsp_key_position))

   // Every result carries a key byte, a verdict, or both.
   `ASSERT_IMPLY(a_has_purpose, clock, reset, rsp_valid, rsp_has_key_byte || rsp_is_verdict)

   // Without a key byte the key fields read zero.
   `ASSERT_IMPLY(a_key_zero, clock, reset, rsp_valid && !rsp_has_key_byte, rsp_key_value == 8'd0 && rsp_key_position == 5'd0)

   // Status is only reported on a verdict.
   `ASSERT_IMPLY(a_status_zero, clock, reset, rsp_valid && !rsp_is_verdict, rsp_status == 3'd0)

   // Key length agrees with the cipher choice.
   `ASSERT_IMPLY(a_key_len, clock, reset, rsp_valid, (rsp_cipher_choice && rsp_key_bytes == 6'd32) || (!rsp_cipher_choice && (rsp_key_bytes == 6'd16 || rsp_key_bytes == 6'd0)))

endmodule

bind tls13_server_hello_parser_core tshp_checker u_tshp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_has_key_byte  (rsp_has_key_byte),
   .rsp_key_value     (rsp_key_value),
   .rsp_key_position  (rsp_key_position),
   .rsp_is_verdict    (rsp_is_verdict),
   .rsp_status        (rsp_status),
   .rsp_cipher_choice (rsp_cipher_choice),
   .rsp_key_bytes     (rsp_key_bytes)
);
